FILE: design/slbc_pkg.sv
// slbc_pkg: shared types and codes for the status LED and button controller
// used by every module of the block; depends on nothing

package slbc_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int TICK_W     = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_SERIAL_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_ALERT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_BLINK    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST_BLINK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_ON      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_OFF     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_FAULT_IDLE    = 3'd7;

   localparam logic [TICK_W-1:0] LONG_PRESS_RST  = 16'd100;
   localparam logic [TICK_W-1:0] RESET_ALERT_RST = 16'd100;
   localparam logic [TICK_W-1:0] SLOW_BLINK_RST  = 16'd50;
   localparam logic [TICK_W-1:0] FAST_BLINK_RST  = 16'd10;
   localparam logic [TICK_W-1:0] FAULT_ON_RST    = 16'd20;
   localparam logic [TICK_W-1:0] FAULT_OFF_RST   = 16'd20;
   localparam logic [TICK_W-1:0] FAULT_IDLE_RST  = 16'd100;
   localparam logic [TICK_W-1:0] REQ_BLINK_TICKS = 16'd25;

   // modes
   localparam logic [3:0] MODE_STARTUP   = 4'd0;
   localparam logic [3:0] MODE_NO_LINK   = 4'd1;
   localparam logic [3:0] MODE_LINK      = 4'd2;
   localparam logic [3:0] MODE_CLIENT    = 4'd3;
   localparam logic [3:0] MODE_ALERT     = 4'd4;
   localparam logic [3:0] MODE_ACTION    = 4'd5;
   localparam logic [3:0] MODE_FAULT     = 4'd6;
   localparam logic [3:0] MODE_UPD_REQ   = 4'd7;
   localparam logic [3:0] MODE_UPD_PROC  = 4'd8;

   // LED patterns
   localparam logic [3:0] PAT_STEADY     = 4'd0;
   localparam logic [3:0] PAT_SLOW_ON    = 4'd1;
   localparam logic [3:0] PAT_SLOW_OFF   = 4'd2;
   localparam logic [3:0] PAT_FAST_ON    = 4'd3;
   localparam logic [3:0] PAT_FAST_OFF   = 4'd4;
   localparam logic [3:0] PAT_FAULT_ON   = 4'd5;
   localparam logic [3:0] PAT_FAULT_OFF  = 4'd6;
   localparam logic [3:0] PAT_FAULT_IDLE = 4'd7;
   localparam logic [3:0] PAT_REQ_RED    = 4'd8;
   localparam logic [3:0] PAT_REQ_GREEN  = 4'd9;
   localparam logic [3:0] PAT_UPD_ON     = 4'd10;
   localparam logic [3:0] PAT_UPD_OFF    = 4'd11;

   // event bits
   localparam int EV_STARTUP   = 0;
   localparam int EV_UPD_REQ   = 1;
   localparam int EV_UPD_PROC  = 2;
   localparam int EV_UPD_DONE  = 3;
   localparam int EV_REBOOT    = 4;

   typedef struct packed {
      logic              serial_mode;
      logic [TICK_W-1:0] long_press_ticks;
      logic [TICK_W-1:0] reset_alert_ticks;
      logic [TICK_W-1:0] slow_blink_ticks;
      logic [TICK_W-1:0] fast_blink_ticks;
      logic [TICK_W-1:0] fault_on_ticks;
      logic [TICK_W-1:0] fault_off_ticks;
      logic [TICK_W-1:0] fault_idle_ticks;
   } csr_type;

   typedef struct packed {
      logic       button_pressed;
      logic       link_enabled;
      logic       link_up;
      logic       client_up;
      logic       fault_report;
      logic [3:0] fault_code;
      logic [4:0] events;
      logic       reinit_ok;
   } item_type;

   typedef struct packed {
      logic       red_on;
      logic       green_on;
      logic [3:0] mode_state;
      logic       update_enable_pulse;
      logic       update_end_pulse;
      logic       reboot_pulse;
   } result_type;

endpackage

FILE: design/slbc_csr.sv
// slbc_csr: configuration registers of the status LED and button controller
// depends on slbc_pkg

module slbc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [slbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slbc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output slbc_pkg::csr_type               cfg
);

   slbc_pkg::csr_type cfg_ff;
   slbc_pkg::csr_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            slbc_pkg::CSR_SERIAL_MODE: cfg_in.serial_mode       = csr_wdata[0];
            slbc_pkg::CSR_LONG_PRESS:  cfg_in.long_press_ticks  = csr_wdata;
            slbc_pkg::CSR_RESET_ALERT: cfg_in.reset_alert_ticks = csr_wdata;
            slbc_pkg::CSR_SLOW_BLINK:  cfg_in.slow_blink_ticks  = csr_wdata;
            slbc_pkg::CSR_FAST_BLINK:  cfg_in.fast_blink_ticks  = csr_wdata;
            slbc_pkg::CSR_FAULT_ON:    cfg_in.fault_on_ticks    = csr_wdata;
            slbc_pkg::CSR_FAULT_OFF:   cfg_in.fault_off_ticks   = csr_wdata;
            slbc_pkg::CSR_FAULT_IDLE:  cfg_in.fault_idle_ticks  = csr_wdata;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.serial_mode       <= 1'b0;
         cfg_ff.long_press_ticks  <= slbc_pkg::LONG_PRESS_RST;
         cfg_ff.reset_alert_ticks <= slbc_pkg::RESET_ALERT_RST;
         cfg_ff.slow_blink_ticks  <= slbc_pkg::SLOW_BLINK_RST;
         cfg_ff.fast_blink_ticks  <= slbc_pkg::FAST_BLINK_RST;
         cfg_ff.fault_on_ticks    <= slbc_pkg::FAULT_ON_RST;
         cfg_ff.fault_off_ticks   <= slbc_pkg::FAULT_OFF_RST;
         cfg_ff.fault_idle_ticks  <= slbc_pkg::FAULT_IDLE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/slbc_core.sv
// slbc_core: controller state and the single-tick step (fault, events, LED
// pattern, button debounce, mode machine); depends on slbc_pkg

module slbc_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  slbc_pkg::item_type    item,
   input  slbc_pkg::csr_type     cfg,
   output slbc_pkg::result_type  result
);

   typedef struct packed {
      logic [3:0]                    mode;
      logic [3:0]                    saved;
      logic [3:0]                    pattern;
      logic [slbc_pkg::TICK_W-1:0]   ptimer;
      logic [slbc_pkg::TICK_W-1:0]   atimer;
      logic [3:0]                    pcount;
      logic [3:0]                    fkind;
      logic [1:0]                    led;
   } st_type;

   st_type                      st_ff, st_in;
   logic                        last_button_ff, last_button_in;
   logic                        button_held_ff, button_held_in;
   logic [slbc_pkg::TICK_W-1:0] press_timer_ff, press_timer_in;

   function automatic st_type enter_pattern(st_type s, logic [3:0] p,
                                            slbc_pkg::csr_type c);
      st_type r;
      r = s;
      r.pattern = p;
      unique case (p)
         slbc_pkg::PAT_SLOW_ON:    begin r.ptimer = c.slow_blink_ticks; r.led = 2'b11; end
         slbc_pkg::PAT_SLOW_OFF:   begin r.ptimer = c.slow_blink_ticks; r.led = 2'b00; end
         slbc_pkg::PAT_FAST_ON:    begin r.ptimer = c.fast_blink_ticks; r.led = 2'b11; end
         slbc_pkg::PAT_FAST_OFF:   begin r.ptimer = c.fast_blink_ticks; r.led = 2'b00; end
         slbc_pkg::PAT_FAULT_ON:   begin r.ptimer = c.fault_on_ticks;   r.led = 2'b01; end
         slbc_pkg::PAT_FAULT_OFF:  begin r.ptimer = c.fault_off_ticks;  r.led = 2'b00; end
         slbc_pkg::PAT_FAULT_IDLE: begin r.ptimer = c.fault_idle_ticks; r.led = 2'b00; end
         slbc_pkg::PAT_REQ_RED:    begin r.ptimer = slbc_pkg::REQ_BLINK_TICKS; r.led = 2'b01; end
         slbc_pkg::PAT_REQ_GREEN:  begin r.ptimer = slbc_pkg::REQ_BLINK_TICKS; r.led = 2'b10; end
         slbc_pkg::PAT_UPD_ON:     begin r.ptimer = c.fast_blink_ticks; r.led = 2'b10; end
         slbc_pkg::PAT_UPD_OFF:    begin r.ptimer = c.fast_blink_ticks; r.led = 2'b00; end
         default:                  r = r;
      endcase
      return r;
   endfunction

   function automatic st_type enter_mode(st_type s, logic [3:0] m,
                                         slbc_pkg::csr_type c, logic ok);
      st_type r;
      r = s;
      r.mode = m;
      unique case (m)
         slbc_pkg::MODE_STARTUP: begin
            r.led = 2'b01;
            r = enter_pattern(r, slbc_pkg::PAT_STEADY, c);
         end
         slbc_pkg::MODE_NO_LINK: r = enter_pattern(r, slbc_pkg::PAT_SLOW_ON, c);
         slbc_pkg::MODE_LINK: begin
            r.led = 2'b11;
            r = enter_pattern(r, slbc_pkg::PAT_STEADY, c);
         end
         slbc_pkg::MODE_CLIENT: begin
            r.led = 2'b10;
            r = enter_pattern(r, slbc_pkg::PAT_STEADY, c);
         end
         slbc_pkg::MODE_ALERT: begin
            r = enter_pattern(r, slbc_pkg::PAT_FAST_ON, c);
            r.atimer = c.reset_alert_ticks;
         end
         slbc_pkg::MODE_ACTION: begin
            if (!ok) begin
               r = enter_pattern(r, slbc_pkg::PAT_FAULT_ON, c);
               r.mode = slbc_pkg::MODE_FAULT;
            end
         end
         slbc_pkg::MODE_FAULT: begin
            if (r.fkind != 4'd0) begin
               r.pcount = r.fkind;
               r = enter_pattern(r, slbc_pkg::PAT_FAULT_ON, c);
            end
         end
         slbc_pkg::MODE_UPD_REQ:  r = enter_pattern(r, slbc_pkg::PAT_REQ_RED, c);
         slbc_pkg::MODE_UPD_PROC: r = enter_pattern(r, slbc_pkg::PAT_UPD_ON, c);
         default:                 r = r;
      endcase
      return r;
   endfunction

   always_comb begin
      st_type s;
      logic   held;
      logic   lastb;
      logic [slbc_pkg::TICK_W-1:0] ptm;
      logic   released;
      logic   long_p;
      logic   short_p;
      logic   upd_en;
      logic   upd_end;
      logic   ok;

      s        = st_ff;
      held     = button_held_ff;
      lastb    = last_button_ff;
      ptm      = press_timer_ff;
      released = 1'b0;
      long_p   = 1'b0;
      upd_en   = 1'b0;
      upd_end  = 1'b0;
      ok       = item.reinit_ok;

      // fault report
      if (item.fault_report) begin
         s.fkind = item.fault_code;
         if (item.fault_code != 4'd0) begin
            if (s.mode != slbc_pkg::MODE_UPD_PROC) s.saved = s.mode;
            s = enter_mode(s, slbc_pkg::MODE_FAULT, cfg, ok);
         end else begin
            s = enter_mode(s, s.saved, cfg, ok);
         end
      end

      // events
      if (item.events[slbc_pkg::EV_STARTUP] && s.mode != slbc_pkg::MODE_FAULT)
         s = enter_mode(s, cfg.serial_mode ? slbc_pkg::MODE_CLIENT : slbc_pkg::MODE_NO_LINK,
                        cfg, ok);
      if (item.events[slbc_pkg::EV_UPD_REQ]) begin
         if (s.mode != slbc_pkg::MODE_FAULT) s.saved = s.mode;
         s = enter_mode(s, slbc_pkg::MODE_UPD_REQ, cfg, ok);
      end
      if (item.events[slbc_pkg::EV_UPD_PROC])
         s = enter_mode(s, slbc_pkg::MODE_UPD_PROC, cfg, ok);
      if (item.events[slbc_pkg::EV_UPD_DONE])
         s = enter_mode(s, s.saved, cfg, ok);

      // LED pattern
      if (s.pattern != slbc_pkg::PAT_STEADY && s.pattern <= slbc_pkg::PAT_UPD_OFF) begin
         s.ptimer = s.ptimer - 16'd1;
         if (s.ptimer == '0) begin
            case (s.pattern)
               slbc_pkg::PAT_SLOW_ON:   s = enter_pattern(s, slbc_pkg::PAT_SLOW_OFF, cfg);
               slbc_pkg::PAT_SLOW_OFF:  s = enter_pattern(s, slbc_pkg::PAT_SLOW_ON, cfg);
               slbc_pkg::PAT_FAST_ON:   s = enter_pattern(s, slbc_pkg::PAT_FAST_OFF, cfg);
               slbc_pkg::PAT_FAST_OFF:  s = enter_pattern(s, slbc_pkg::PAT_FAST_ON, cfg);
               slbc_pkg::PAT_FAULT_ON:  s = enter_pattern(s, slbc_pkg::PAT_FAULT_OFF, cfg);
               slbc_pkg::PAT_FAULT_OFF: begin
                  s.pcount = s.pcount - 4'd1;
                  s = enter_pattern(s, (s.pcount == 4'd0) ? slbc_pkg::PAT_FAULT_IDLE
                                                          : slbc_pkg::PAT_FAULT_ON, cfg);
               end
               slbc_pkg::PAT_FAULT_IDLE: begin
                  s.pcount = s.fkind;
                  s = enter_pattern(s, slbc_pkg::PAT_FAULT_ON, cfg);
               end
               slbc_pkg::PAT_REQ_RED:   s = enter_pattern(s, slbc_pkg::PAT_REQ_GREEN, cfg);
               slbc_pkg::PAT_REQ_GREEN: s = enter_pattern(s, slbc_pkg::PAT_REQ_RED, cfg);
               slbc_pkg::PAT_UPD_ON:    s = enter_pattern(s, slbc_pkg::PAT_UPD_OFF, cfg);
               slbc_pkg::PAT_UPD_OFF:   s = enter_pattern(s, slbc_pkg::PAT_UPD_ON, cfg);
               default:                 s = s;
            endcase
         end
      end

      // two-sample debounce
      if (item.button_pressed && lastb && !held) begin
         held = 1'b1;
         ptm  = cfg.long_press_ticks;
      end
      if (!item.button_pressed && !lastb && held) begin
         held     = 1'b0;
         released = 1'b1;
      end
      lastb = item.button_pressed;
      if (held && ptm != '0) begin
         ptm = ptm - 16'd1;
         if (ptm == '0) long_p = 1'b1;
      end
      short_p = released && (ptm != '0);

      // link and reset machine, plus the update button pulses
      unique case (s.mode)
         slbc_pkg::MODE_STARTUP: s = s;
         slbc_pkg::MODE_NO_LINK: begin
            if (long_p) s = enter_mode(s, slbc_pkg::MODE_ALERT, cfg, ok);
            else if (item.link_up) s = enter_mode(s, slbc_pkg::MODE_LINK, cfg, ok);
         end
         slbc_pkg::MODE_LINK: begin
            if (long_p) s = enter_mode(s, slbc_pkg::MODE_ALERT, cfg, ok);
            else if (!item.link_up) s = enter_mode(s, slbc_pkg::MODE_NO_LINK, cfg, ok);
            else if (item.client_up) s = enter_mode(s, slbc_pkg::MODE_CLIENT, cfg, ok);
         end
         slbc_pkg::MODE_CLIENT: begin
            if (!cfg.serial_mode) begin
               if (long_p) s = enter_mode(s, slbc_pkg::MODE_ALERT, cfg, ok);
               else if (!item.client_up) s = enter_mode(s, slbc_pkg::MODE_NO_LINK, cfg, ok);
            end
         end
         slbc_pkg::MODE_ALERT: begin
            s.atimer = s.atimer - 16'd1;
            if (s.atimer == '0) s = enter_mode(s, slbc_pkg::MODE_ACTION, cfg, ok);
         end
         slbc_pkg::MODE_ACTION: begin
            if (item.link_enabled)
               s = enter_mode(s, (s.fkind == 4'd0) ? slbc_pkg::MODE_NO_LINK
                                                    : slbc_pkg::MODE_FAULT, cfg, ok);
         end
         slbc_pkg::MODE_FAULT: begin
            if (!cfg.serial_mode && long_p) s = enter_mode(s, slbc_pkg::MODE_ALERT, cfg, ok);
         end
         slbc_pkg::MODE_UPD_REQ:  upd_en  = short_p;
         slbc_pkg::MODE_UPD_PROC: upd_end = short_p;
         default:                 s = enter_mode(s, slbc_pkg::MODE_NO_LINK, cfg, ok);
      endcase

      st_in          = s;
      button_held_in = held;
      last_button_in = lastb;
      press_timer_in = ptm;

      result.red_on              = s.led[0];
      result.green_on            = s.led[1];
      result.mode_state          = s.mode;
      result.update_enable_pulse = upd_en;
      result.update_end_pulse    = upd_end;
      result.reboot_pulse        = item.events[slbc_pkg::EV_REBOOT];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode     <= slbc_pkg::MODE_STARTUP;
         st_ff.saved    <= slbc_pkg::MODE_STARTUP;
         st_ff.pattern  <= slbc_pkg::PAT_STEADY;
         st_ff.ptimer   <= '0;
         st_ff.atimer   <= '0;
         st_ff.pcount   <= '0;
         st_ff.fkind    <= '0;
         st_ff.led      <= 2'b01;
         last_button_ff <= 1'b0;
         button_held_ff <= 1'b0;
         press_timer_ff <= '0;
      end else if (step) begin
         st_ff          <= st_in;
         last_button_ff <= last_button_in;
         button_held_ff <= button_held_in;
         press_timer_ff <= press_timer_in;
      end
   end

endmodule

FILE: design/status_led_button_controller.sv
// status_led_button_controller: top level, input register, tick step and result register
// depends on slbc_pkg, slbc_csr and slbc_core
//
//  channel  dir  handshake        payload
//  req_     in   tvalid/tready    tdata[13:0] item, tuser = fault_report
//  rsp_     out  tvalid/tready    tdata[8:0] result
//  csr_     in   csr_we           csr_index[2:0], csr_wdata[15:0]
//
// one tick per cycle while rsp is not stalled: an accepted transaction lands in the input
// register, the step logic works on it once the result register is free and its result lands
// in the result register, which raises rsp valid
// synchronous reset clears all control and controller state
// a stalled rsp holds its result while one more transaction waits in the input register

module status_led_button_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // button_pressed, link_enabled, link_up, client_up, fault_code[3:0],
   // events[4:0], reinit_ok, zero fill
   input  logic [15:0]                     req_tdata,
   // fault_report
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // red_on, green_on, mode_state[3:0], update_enable_pulse, update_end_pulse,
   // reboot_pulse, zero fill
   output logic [15:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [slbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slbc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   slbc_pkg::csr_type    cfg;
   slbc_pkg::item_type   in_item_ff, in_item_in;
   slbc_pkg::result_type out_res_ff, step_res;
   logic                 in_valid_ff, in_valid_in;
   logic                 out_valid_ff, out_valid_in;
   logic                 advance;
   logic                 req_fire;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      in_item_in.button_pressed = req_tdata[0];
      in_item_in.link_enabled   = req_tdata[1];
      in_item_in.link_up        = req_tdata[2];
      in_item_in.client_up      = req_tdata[3];
      in_item_in.fault_report   = req_tuser;
      in_item_in.fault_code     = req_tdata[7:4];
      in_item_in.events         = req_tdata[12:8];
      in_item_in.reinit_ok      = req_tdata[13];
      in_valid_in  = req_fire || (in_valid_ff && !advance);
      out_valid_in = advance || (out_valid_ff && !rsp_tready);
   end

   slbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   slbc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (step_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) in_item_ff <= in_item_in;
      if (advance)  out_res_ff <= step_res;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0,
                        out_res_ff.reboot_pulse,
                        out_res_ff.update_end_pulse,
                        out_res_ff.update_enable_pulse,
                        out_res_ff.mode_state,
                        out_res_ff.green_on,
                        out_res_ff.red_on};

endmodule

FILE: design/slbc_checker.sv
// slbc_checker: port-level assertions for the status LED and button controller
// bound to status_led_button_controller; depends on slbc_pkg

module slbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_upd_en_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6] |-> rsp_tdata[5:2] == slbc_pkg::MODE_UPD_REQ)
      else $error("update enable outside update request");

   a_upd_end_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[7] |-> rsp_tdata[5:2] == slbc_pkg::MODE_UPD_PROC)
      else $error("update end outside update process");

   a_client_green: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5:2] == slbc_pkg::MODE_CLIENT |->
         rsp_tdata[1] && !rsp_tdata[0])
      else $error("client mode without steady green");

endmodule

bind status_led_button_controller slbc_checker u_slbc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

FILE: tb/slbc_tick_checker.sv
// slbc_tick_checker: watches the req, rsp and csr ports of the status LED and button
// controller, predicts each result tick by tick and compares it on arrival
// depends on slbc_pkg

module slbc_tick_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [15:0]                     req_tdata,
   input  logic                            req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [15:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [slbc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [slbc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatch_count,
   output int                              pending
);

   timeunit 1ns;
   timeprecision 1ps;

   slbc_pkg::csr_type     regs;
   logic [3:0]            m_mode, m_saved, m_pat, m_pulses, m_fkind;
   logic [15:0]           m_ptimer, m_atimer, m_press;
   logic                  m_red, m_green, m_last_btn, m_held, m_reinit;

   slbc_pkg::result_type  predicted_status[$];
   slbc_pkg::result_type  want, got;
   slbc_pkg::item_type    tick_in;
   int                    rsp_seen;

   function void set_leds(input logic red, input logic green);
      m_red   = red;
      m_green = green;
   endfunction

   function void start_pattern(input logic [3:0] p);
      m_pat = p;
      case (p)
         slbc_pkg::PAT_SLOW_ON: begin
            m_ptimer = regs.slow_blink_ticks; set_leds(1'b1, 1'b1);
         end
         slbc_pkg::PAT_SLOW_OFF: begin
            m_ptimer = regs.slow_blink_ticks; set_leds(1'b0, 1'b0);
         end
         slbc_pkg::PAT_FAST_ON: begin
            m_ptimer = regs.fast_blink_ticks; set_leds(1'b1, 1'b1);
         end
         slbc_pkg::PAT_FAST_OFF: begin
            m_ptimer = regs.fast_blink_ticks; set_leds(1'b0, 1'b0);
         end
         slbc_pkg::PAT_FAULT_ON: begin
            m_ptimer = regs.fault_on_ticks; set_leds(1'b1, 1'b0);
         end
         slbc_pkg::PAT_FAULT_OFF: begin
            m_ptimer = regs.fault_off_ticks; set_leds(1'b0, 1'b0);
         end
         slbc_pkg::PAT_FAULT_IDLE: begin
            m_ptimer = regs.fault_idle_ticks; set_leds(1'b0, 1'b0);
         end
         slbc_pkg::PAT_REQ_RED: begin
            m_ptimer = slbc_pkg::REQ_BLINK_TICKS; set_leds(1'b1, 1'b0);
         end
         slbc_pkg::PAT_REQ_GREEN: begin
            m_ptimer = slbc_pkg::REQ_BLINK_TICKS; set_leds(1'b0, 1'b1);
         end
         slbc_pkg::PAT_UPD_ON: begin
            m_ptimer = regs.fast_blink_ticks; set_leds(1'b0, 1'b1);
         end
         slbc_pkg::PAT_UPD_OFF: begin
            m_ptimer = regs.fast_blink_ticks; set_leds(1'b0, 1'b0);
         end
         default: ;
      endcase
   endfunction

   function void enter_mode(input logic [3:0] m);
      m_mode = m;
      case (m)
         slbc_pkg::MODE_STARTUP: begin
            set_leds(1'b1, 1'b0); start_pattern(slbc_pkg::PAT_STEADY);
         end
         slbc_pkg::MODE_NO_LINK: start_pattern(slbc_pkg::PAT_SLOW_ON);
         slbc_pkg::MODE_LINK: begin
            set_leds(1'b1, 1'b1); start_pattern(slbc_pkg::PAT_STEADY);
         end
         slbc_pkg::MODE_CLIENT: begin
            set_leds(1'b0, 1'b1); start_pattern(slbc_pkg::PAT_STEADY);
         end
         slbc_pkg::MODE_ALERT: begin
            start_pattern(slbc_pkg::PAT_FAST_ON);
            m_atimer = regs.reset_alert_ticks;
         end
         slbc_pkg::MODE_ACTION: begin
            // failed reinit drops straight into the fault blink
            if (!m_reinit) begin
               start_pattern(slbc_pkg::PAT_FAULT_ON);
               m_mode = slbc_pkg::MODE_FAULT;
            end
         end
         slbc_pkg::MODE_FAULT: begin
            if (m_fkind != 4'd0) begin
               m_pulses = m_fkind;
               start_pattern(slbc_pkg::PAT_FAULT_ON);
            end
         end
         slbc_pkg::MODE_UPD_REQ:  start_pattern(slbc_pkg::PAT_REQ_RED);
         slbc_pkg::MODE_UPD_PROC: start_pattern(slbc_pkg::PAT_UPD_ON);
         default: ;
      endcase
   endfunction

   function logic blink_expired();
      m_ptimer = m_ptimer - 16'd1;
      return m_ptimer == 16'd0;
   endfunction

   function void blink_step();
      case (m_pat)
         slbc_pkg::PAT_SLOW_ON:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_SLOW_OFF);
         slbc_pkg::PAT_SLOW_OFF:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_SLOW_ON);
         slbc_pkg::PAT_FAST_ON:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_FAST_OFF);
         slbc_pkg::PAT_FAST_OFF:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_FAST_ON);
         slbc_pkg::PAT_FAULT_ON:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_FAULT_OFF);
         slbc_pkg::PAT_FAULT_OFF: begin
            if (blink_expired()) begin
               m_pulses = m_pulses - 4'd1;
               start_pattern(m_pulses == 4'd0 ? slbc_pkg::PAT_FAULT_IDLE
                                              : slbc_pkg::PAT_FAULT_ON);
            end
         end
         slbc_pkg::PAT_FAULT_IDLE: begin
            if (blink_expired()) begin
               m_pulses = m_fkind;
               start_pattern(slbc_pkg::PAT_FAULT_ON);
            end
         end
         slbc_pkg::PAT_REQ_RED:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_REQ_GREEN);
         slbc_pkg::PAT_REQ_GREEN:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_REQ_RED);
         slbc_pkg::PAT_UPD_ON:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_UPD_OFF);
         slbc_pkg::PAT_UPD_OFF:
            if (blink_expired()) start_pattern(slbc_pkg::PAT_UPD_ON);
         default: ;
      endcase
   endfunction

   function slbc_pkg::result_type advance_tick(input slbc_pkg::item_type t);
      logic                 released, long_p, short_p;
      slbc_pkg::result_type r;
      released = 1'b0;
      long_p   = 1'b0;
      r        = '0;
      m_reinit = t.reinit_ok;

      if (t.fault_report) begin
         m_fkind = t.fault_code;
         if (t.fault_code != 4'd0) begin
            // a fault during update process keeps the saved mode
            if (m_mode != slbc_pkg::MODE_UPD_PROC) m_saved = m_mode;
            enter_mode(slbc_pkg::MODE_FAULT);
         end else begin
            enter_mode(m_saved);
         end
      end

      if (t.events[slbc_pkg::EV_STARTUP] && m_mode != slbc_pkg::MODE_FAULT)
         enter_mode(regs.serial_mode ? slbc_pkg::MODE_CLIENT
                                     : slbc_pkg::MODE_NO_LINK);
      if (t.events[slbc_pkg::EV_UPD_REQ]) begin
         if (m_mode != slbc_pkg::MODE_FAULT) m_saved = m_mode;
         enter_mode(slbc_pkg::MODE_UPD_REQ);
      end
      if (t.events[slbc_pkg::EV_UPD_PROC]) enter_mode(slbc_pkg::MODE_UPD_PROC);
      if (t.events[slbc_pkg::EV_UPD_DONE]) enter_mode(m_saved);

      blink_step();

      // two matching samples make a press or a release
      if (t.button_pressed && m_last_btn && !m_held) begin
         m_held  = 1'b1;
         m_press = regs.long_press_ticks;
      end
      if (!t.button_pressed && !m_last_btn && m_held) begin
         m_held   = 1'b0;
         released = 1'b1;
      end
      m_last_btn = t.button_pressed;
      if (m_held && m_press != 16'd0) begin
         m_press = m_press - 16'd1;
         if (m_press == 16'd0) long_p = 1'b1;
      end
      short_p = released && (m_press != 16'd0);

      case (m_mode)
         slbc_pkg::MODE_STARTUP: ;
         slbc_pkg::MODE_NO_LINK: begin
            if (long_p) enter_mode(slbc_pkg::MODE_ALERT);
            else if (t.link_up) enter_mode(slbc_pkg::MODE_LINK);
         end
         slbc_pkg::MODE_LINK: begin
            if (long_p) enter_mode(slbc_pkg::MODE_ALERT);
            else if (!t.link_up) enter_mode(slbc_pkg::MODE_NO_LINK);
            else if (t.client_up) enter_mode(slbc_pkg::MODE_CLIENT);
         end
         slbc_pkg::MODE_CLIENT: begin
            if (!regs.serial_mode) begin
               if (long_p) enter_mode(slbc_pkg::MODE_ALERT);
               else if (!t.client_up) enter_mode(slbc_pkg::MODE_NO_LINK);
            end
         end
         slbc_pkg::MODE_ALERT: begin
            m_atimer = m_atimer - 16'd1;
            if (m_atimer == 16'd0) enter_mode(slbc_pkg::MODE_ACTION);
         end
         slbc_pkg::MODE_ACTION: begin
            if (t.link_enabled)
               enter_mode(m_fkind == 4'd0 ? slbc_pkg::MODE_NO_LINK : slbc_pkg::MODE_FAULT);
         end
         slbc_pkg::MODE_FAULT: begin
            if (!regs.serial_mode && long_p) enter_mode(slbc_pkg::MODE_ALERT);
         end
         slbc_pkg::MODE_UPD_REQ:  r.update_enable_pulse = short_p;
         slbc_pkg::MODE_UPD_PROC: r.update_end_pulse = short_p;
         default: enter_mode(slbc_pkg::MODE_NO_LINK);
      endcase

      r.red_on       = m_red;
      r.green_on     = m_green;
      r.mode_state   = m_mode;
      r.reboot_pulse = t.events[slbc_pkg::EV_REBOOT];
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         regs.serial_mode       = 1'b0;
         regs.long_press_ticks  = slbc_pkg::LONG_PRESS_RST;
         regs.reset_alert_ticks = slbc_pkg::RESET_ALERT_RST;
         regs.slow_blink_ticks  = slbc_pkg::SLOW_BLINK_RST;
         regs.fast_blink_ticks  = slbc_pkg::FAST_BLINK_RST;
         regs.fault_on_ticks    = slbc_pkg::FAULT_ON_RST;
         regs.fault_off_ticks   = slbc_pkg::FAULT_OFF_RST;
         regs.fault_idle_ticks  = slbc_pkg::FAULT_IDLE_RST;
         m_mode     = slbc_pkg::MODE_STARTUP;
         m_saved    = slbc_pkg::MODE_STARTUP;
         m_pat      = slbc_pkg::PAT_STEADY;
         m_ptimer   = '0;
         m_atimer   = '0;
         m_pulses   = '0;
         m_fkind    = '0;
         m_red      = 1'b1;
         m_green    = 1'b0;
         m_last_btn = 1'b0;
         m_held     = 1'b0;
         m_press    = '0;
         m_reinit   = 1'b0;
         rsp_seen   = 0;
         predicted_status.delete();
         pending   <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               slbc_pkg::CSR_SERIAL_MODE: regs.serial_mode       = csr_wdata[0];
               slbc_pkg::CSR_LONG_PRESS:  regs.long_press_ticks  = csr_wdata;
               slbc_pkg::CSR_RESET_ALERT: regs.reset_alert_ticks = csr_wdata;
               slbc_pkg::CSR_SLOW_BLINK:  regs.slow_blink_ticks  = csr_wdata;
               slbc_pkg::CSR_FAST_BLINK:  regs.fast_blink_ticks  = csr_wdata;
               slbc_pkg::CSR_FAULT_ON:    regs.fault_on_ticks    = csr_wdata;
               slbc_pkg::CSR_FAULT_OFF:   regs.fault_off_ticks   = csr_wdata;
               slbc_pkg::CSR_FAULT_IDLE:  regs.fault_idle_ticks  = csr_wdata;
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got.red_on              = rsp_tdata[0];
            got.green_on            = rsp_tdata[1];
            got.mode_state          = rsp_tdata[5:2];
            got.update_enable_pulse = rsp_tdata[6];
            got.update_end_pulse    = rsp_tdata[7];
            got.reboot_pulse        = rsp_tdata[8];
            if (predicted_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("rsp transaction %0d arrived with nothing outstanding: %h",
                           rsp_seen, rsp_tdata);
            end else begin
               want = predicted_status.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $write("rsp transaction %0d: expected red %b green %b mode %0d ",
                            rsp_seen, want.red_on, want.green_on, want.mode_state);
                     $write("upd_en %b upd_end %b reboot %b, ",
                            want.update_enable_pulse, want.update_end_pulse,
                            want.reboot_pulse);
                     $write("got red %b green %b mode %0d ",
                            got.red_on, got.green_on, got.mode_state);
                     $display("upd_en %b upd_end %b reboot %b",
                              got.update_enable_pulse, got.update_end_pulse,
                              got.reboot_pulse);
                  end
               end
            end
            rsp_seen++;
         end

         if (req_tvalid && req_tready) begin
            tick_in.button_pressed = req_tdata[0];
            tick_in.link_enabled   = req_tdata[1];
            tick_in.link_up        = req_tdata[2];
            tick_in.client_up      = req_tdata[3];
            tick_in.fault_code     = req_tdata[7:4];
            tick_in.events         = req_tdata[12:8];
            tick_in.reinit_ok      = req_tdata[13];
            tick_in.fault_report   = req_tuser;
            predicted_status.push_back(advance_tick(tick_in));
         end

         pending <= predicted_status.size();
      end
   end

endmodule

FILE: tb/status_led_button_controller_tb.sv
// status_led_button_controller_tb: drives ticks and register writes into the controller
// under several timing settings and idle profiles, and gives the verdict
// depends on slbc_pkg, status_led_button_controller and slbc_tick_checker

module status_led_button_controller_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES  = 60;
   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 56;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [15:0]                     req_tdata = '0;
   logic                            req_tuser = 1'b0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [15:0]                     rsp_tdata;
   logic                            csr_we = 1'b0;
   logic [slbc_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [slbc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int mismatch_count;
   int pending;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int hold_asked    = 0;

   logic lvl_btn = 1'b0, lvl_up = 1'b0, lvl_client = 1'b0;

   status_led_button_controller u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   slbc_tick_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending        (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #200000;
      $display("simulation failed");
      $finish;
   end

   // receiver: random stalls, plus a long hold-off whenever one is asked for
   initial begin : rsp_side
      int served;
      served = 0;
      forever begin
         @(posedge clock);
         if (hold_asked != served) begin
            served++;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic offer_tick(input slbc_pkg::item_type t);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, t.reinit_ok, t.events, t.fault_code, t.client_up, t.link_up,
                     t.link_enabled, t.button_pressed};
      req_tuser  <= t.fault_report;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic offer_fields(input logic btn, input logic en, input logic up,
                               input logic cl, input logic rep, input logic [3:0] code,
                               input logic [4:0] ev, input logic ok);
      slbc_pkg::item_type t;
      t.button_pressed = btn;
      t.link_enabled   = en;
      t.link_up        = up;
      t.client_up      = cl;
      t.fault_report   = rep;
      t.fault_code     = code;
      t.events         = ev;
      t.reinit_ok      = ok;
      offer_tick(t);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [slbc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [slbc_pkg::CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_timing(input logic serial, input logic [15:0] long_press,
                                 input logic [15:0] alert, input logic [15:0] slow,
                                 input logic [15:0] fast, input logic [15:0] on_t,
                                 input logic [15:0] off_t, input logic [15:0] idle_t);
      write_reg(slbc_pkg::CSR_SERIAL_MODE, {15'd0, serial});
      write_reg(slbc_pkg::CSR_LONG_PRESS, long_press);
      write_reg(slbc_pkg::CSR_RESET_ALERT, alert);
      write_reg(slbc_pkg::CSR_SLOW_BLINK, slow);
      write_reg(slbc_pkg::CSR_FAST_BLINK, fast);
      write_reg(slbc_pkg::CSR_FAULT_ON, on_t);
      write_reg(slbc_pkg::CSR_FAULT_OFF, off_t);
      write_reg(slbc_pkg::CSR_FAULT_IDLE, idle_t);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // phase 1 all ones, phase 2 all zero (wrapping timers), phase 3 all ones in every bit
   function automatic logic [15:0] timing_for(input int k, input int hi);
      case (k)
         1:       return 16'd1;
         2:       return 16'd0;
         3:       return 16'hFFFF;
         default: return 16'($urandom_range(1, hi));
      endcase
   endfunction

   // mostly slowly changing levels with rare events, some pure noise
   task automatic next_random_tick(output slbc_pkg::item_type t);
      if ($urandom_range(9) == 0) begin
         t = slbc_pkg::item_type'(14'($urandom));
      end else begin
         if ($urandom_range(5) == 0)  lvl_btn    = !lvl_btn;
         if ($urandom_range(11) == 0) lvl_up     = !lvl_up;
         if ($urandom_range(7) == 0)  lvl_client = !lvl_client;
         t.button_pressed = lvl_btn;
         t.link_up        = lvl_up;
         t.client_up      = lvl_client;
         t.link_enabled   = 1'($urandom_range(1));
         t.reinit_ok      = ($urandom_range(3) != 0);
         t.fault_report   = ($urandom_range(15) == 0);
         t.fault_code     = ($urandom_range(3) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
         t.events         = '0;
         for (int b = slbc_pkg::EV_STARTUP; b <= slbc_pkg::EV_REBOOT; b++)
            t.events[b] = ($urandom_range(19) == 0);
      end
   endtask

   initial begin : stimulus
      slbc_pkg::item_type t;
      logic               serial;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      program_timing(1'b0, 16'd3, 16'd2, 16'd2, 16'd1, 16'd1, 16'd1, 16'd2);

      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00001, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      // long press into reset alert, then a failed reinit
      offer_fields(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b1);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00001, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd15, 5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd0,  5'b00000, 1'b0);
      // short press in update request, then a fault while updating
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00010, 1'b0);
      offer_fields(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b00100, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd3,  5'b00000, 1'b0);
      offer_fields(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0,  5'b01000, 1'b0);
      offer_fields(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'd15, 5'b11111, 1'b1);

      for (int k = 1; k <= PHASES; k++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         serial = (k == 1 || k == 3) ? 1'b1 : 1'($urandom_range(1));
         program_timing(serial, timing_for(k, 9), timing_for(k, 6), timing_for(k, 6),
                        timing_for(k, 6), timing_for(k, 6), timing_for(k, 6),
                        timing_for(k, 6));
         case (k % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 58; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 58; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (k % 4 == 0 && n == 10) hold_asked++;
            if (k == 5 && n == PHASE_ITEMS / 2) wait_drained();
            next_random_tick(t);
            offer_tick(t);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
